>>> rtl/utf8_code_point_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef UTF8_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_ASSERT_SVH

// Check that a property holds.
`define U8D_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("utf8 decoder assertion failed");

// Check that a condition never occurs.
`define U8D_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("utf8 decoder forbidden condition seen");

`endif

>>> rtl/utf8d_pkg.sv
package utf8d_pkg;

	// Field widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CP_W       = 21;
	localparam int unsigned PARTIAL_W  = 15;
	localparam int unsigned OUT_DATA_W = 24;

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Replacement character '?'
	localparam logic [CP_W-1:0] QMARK = 21'd63;

	// Sequence lengths; zero means no sequence open
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// Work item for the back part: qcount '?' results, then an optional value
	typedef struct packed {
		logic [1:0]      qcount;
		logic            has_val;
		logic [CP_W-1:0] val;
		logic            fin;
	} cmd_t;

endpackage

>>> rtl/utf8d_front.sv
`include "utf8_code_point_decoder_assert.svh"

module utf8d_front
	import utf8d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  logic              s_tlast,   // final_byte
	input  logic              q_full,
	output logic              push,
	output cmd_t              push_cmd
);

	logic [2:0]           seq_len_q;
	logic [1:0]           taken_q;
	logic [PARTIAL_W-1:0] partial_q;

	logic                 accept;
	logic                 is_cont;
	logic [2:0]           taken_nx;
	logic [CP_W-1:0]      grown;
	logic [2:0]           seq_len_d;
	logic [1:0]           taken_d;
	logic [PARTIAL_W-1:0] partial_d;
	cmd_t                 cmd;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_cont  = (s_tdata[7:6] == 2'b10);
	assign taken_nx = {1'b0, taken_q} + 3'd1;
	assign grown    = {partial_q, s_tdata[5:0]};

	// Classify the byte against the open sequence
	always_comb begin
		seq_len_d   = SEQ_NONE;
		taken_d     = 2'd0;
		partial_d   = '0;
		cmd.qcount  = 2'd0;
		cmd.has_val = 1'b0;
		cmd.val     = QMARK;
		cmd.fin     = s_tlast;
		if (seq_len_q != SEQ_NONE && is_cont) begin
			if (taken_nx == seq_len_q) begin
				cmd.has_val = 1'b1;
				cmd.val     = grown;
			end else if (s_tlast) begin
				cmd.qcount = taken_nx[1:0];
			end else begin
				seq_len_d = seq_len_q;
				taken_d   = taken_nx[1:0];
				partial_d = grown[PARTIAL_W-1:0];
			end
		end else begin
			// Flush a broken sequence, then decode the byte afresh
			cmd.qcount = (seq_len_q != SEQ_NONE) ? taken_q : 2'd0;
			priority if (s_tdata[7] == 1'b0) begin
				cmd.has_val = 1'b1;
				cmd.val     = {{(CP_W-BYTE_W){1'b0}}, s_tdata};
			end else if (s_tdata[7:5] == 3'b110) begin
				if (s_tlast) begin
					cmd.has_val = 1'b1;
				end else begin
					seq_len_d = SEQ_LEN2;
					taken_d   = 2'd1;
					partial_d = {{(PARTIAL_W-5){1'b0}}, s_tdata[4:0]};
				end
			end else if (s_tdata[7:4] == 4'b1110) begin
				if (s_tlast) begin
					cmd.has_val = 1'b1;
				end else begin
					seq_len_d = SEQ_LEN3;
					taken_d   = 2'd1;
					partial_d = {{(PARTIAL_W-4){1'b0}}, s_tdata[3:0]};
				end
			end else if (s_tdata[7:3] == 5'b11110) begin
				if (s_tlast) begin
					cmd.has_val = 1'b1;
				end else begin
					seq_len_d = SEQ_LEN4;
					taken_d   = 2'd1;
					partial_d = {{(PARTIAL_W-3){1'b0}}, s_tdata[2:0]};
				end
			end else begin
				// Stray continuation or F8..FF
				cmd.has_val = 1'b1;
			end
		end
	end

	// Drop bytes that cause no result
	assign push     = accept && (cmd.has_val || cmd.qcount != 2'd0);
	assign push_cmd = cmd;

	// Advance sequence state per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= SEQ_NONE;
			taken_q   <= 2'd0;
			partial_q <= '0;
		end else if (accept) begin
			seq_len_q <= seq_len_d;
			taken_q   <= taken_d;
			partial_q <= partial_d;
		end
	end

	`U8D_ASSERT(a_open_taken_ok, seq_len_q != SEQ_NONE |-> taken_q != 2'd0 && {1'b0, taken_q} < seq_len_q)
	`U8D_ASSERT(a_final_closes, accept && s_tlast |=> seq_len_q == SEQ_NONE)

endmodule

>>> rtl/utf8d_queue.sv
`include "utf8_code_point_decoder_assert.svh"

module utf8d_queue
	import utf8d_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic hd_valid,
	output cmd_t hd_cmd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign hd_valid = (count_q != '0);
	assign hd_cmd   = mem_q[rd_ptr_q];

	// Store pushed work items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`U8D_NEVER(a_push_when_full, push && full)
	`U8D_NEVER(a_pop_when_empty, pop && !hd_valid)

endmodule

>>> rtl/utf8d_back.sv
`include "utf8_code_point_decoder_assert.svh"

module utf8d_back
	import utf8d_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hd_valid,
	input  cmd_t                  hd_cmd,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [20:0] code_point, rest zero
	output logic                  m_tlast,   // text_done
	output logic                  m_tuser    // run_last
);

	logic [1:0]      idx_q;
	logic            m_tvalid_q;
	logic [CP_W-1:0] cp_q;
	logic            done_q;
	logic            run_last_q;

	logic            load;
	logic            take;
	logic            emit_qm;
	logic            last;

	assign load    = !m_tvalid_q || m_tready;
	assign take    = load && hd_valid;
	assign emit_qm = (idx_q != hd_cmd.qcount);
	assign last    = emit_qm ? ((idx_q + 2'd1 == hd_cmd.qcount) && !hd_cmd.has_val) : 1'b1;
	assign pop     = take && last;

	// Expand the head work item into one result per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else begin
			if (load) begin
				m_tvalid_q <= hd_valid;
			end
			if (take) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Hold result payload until taken
	always_ff @(posedge clk) begin
		if (take) begin
			cp_q       <= emit_qm ? QMARK : hd_cmd.val;
			done_q     <= last && hd_cmd.fin;
			run_last_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-CP_W){1'b0}}, cp_q};
	assign m_tlast  = done_q;
	assign m_tuser  = run_last_q;

	`U8D_ASSERT(a_idx_in_range, hd_valid |-> idx_q <= hd_cmd.qcount)
	`U8D_ASSERT(a_idx_idle_zero, !hd_valid |-> idx_q == 2'd0)

endmodule

>>> rtl/utf8_code_point_decoder.sv
// Channel | Direction | tdata                  | tlast      | tuser
// s_*     | in        | [7:0] text_byte        | final_byte | -
// m_*     | out       | [20:0] code_point      | text_done  | run_last
//
// The front decodes one byte per cycle while the queue has room and pushes a
// work item for every byte that causes results; the back emits one result per
// cycle while m_tready is high. A byte causes up to four results, so the
// output side sets the long-run rate, one byte per cycle for well-formed text.
// arst_n clears the open sequence, the queue and the output register.
// Input stalls only when the queue is full; output stalls fill the queue.
module utf8_code_point_decoder
	import utf8d_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] text_byte
	input  logic                  s_tlast,   // final_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic                  m_tlast,   // text_done
	output logic                  m_tuser    // run_last
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic hd_valid;
	cmd_t hd_cmd;

	// Classify bytes and track the open sequence
	utf8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Decouple front and back
	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.hd_valid (hd_valid),
		.hd_cmd   (hd_cmd)
	);

	// Emit results
	utf8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (hd_valid),
		.hd_cmd   (hd_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
